// ===== src/gftq_pkg.sv =====
// gftq_pkg: transaction types and action/status codes for the team queue
// no dependencies; imported by every module of the block

package gftq_pkg;

  localparam int ACT_W     = 2;
  localparam int ELEM_W    = 10;
  localparam int TEAM_ID_W = 5;
  localparam int STATUS_W  = 2;

  localparam logic [ACT_W-1:0] ACT_ASSIGN  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENQUEUE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEQUEUE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [ELEM_W-1:0]    element;
    logic [TEAM_ID_W-1:0] team_id;
  } gftq_cmd_t;

  typedef struct packed {
    logic [ELEM_W-1:0]   element_out;
    logic [STATUS_W-1:0] status;
  } gftq_result_t;

endpackage

// ===== src/gftq_membership.sv =====
// gftq_membership: element-to-team table with a clearing sweep after reset
// depends on gftq_pkg

module gftq_membership import gftq_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int TW    = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [TW-1:0]            wr_team,
  output logic [TW-1:0]            rd_team,
  output logic                     clearing
);

  localparam int AW = $clog2(DEPTH);

  logic [TW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wr_team;
    end
    if (rd_en) begin
      rd_team <= mem[addr];
    end
  end

endmodule

// ===== src/grouped_fifo_team_queue.sv =====
// grouped_fifo_team_queue: team queue top level with team rings and team order ring
// depends on gftq_pkg and gftq_membership
//
// A transaction is taken on any cycle with start high and busy low, one per cycle
// with no gaps needed. Its result is registered in stage one and then in the output
// registers, marked by done for a single cycle: the membership table is read or
// written as a transaction is taken, and stage two updates the team and order rings
// and reads or writes the member store, whose registered read data feeds element_out.
// The receiver cannot stall results. After reset, busy stays high while the
// membership table is swept to team zero.

module grouped_fifo_team_queue import gftq_pkg::*; #(
  parameter int TEAMS       = 32,
  parameter int TEAM_DEPTH  = 64,
  parameter int ELEMENT_IDS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  gftq_cmd_t    cmd,
  output logic         done,
  output gftq_result_t result
);

  localparam int NT  = (TEAMS < 32) ? TEAMS : 32;
  localparam int TW  = (NT > 1) ? $clog2(NT) : 1;
  localparam int CW  = $clog2(TEAM_DEPTH + 1);
  localparam int HW  = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
  localparam int OCW = $clog2(NT + 1);
  localparam int SD  = NT * TEAM_DEPTH;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int MD  = (ELEMENT_IDS < 1024) ? ELEMENT_IDS : 1024;
  localparam int MAW = $clog2(MD);

  function automatic logic [ELEM_W-1:0] reduce_elem(input logic [ELEM_W-1:0] x);
    logic [ELEM_W-1:0] r;
    r = x;
    for (int i = ELEM_W - 1; i >= 0; i--) begin
      if (r >= (MD << i)) begin
        r = r - ELEM_W'(MD << i);
      end
    end
    return r;
  endfunction

  function automatic logic [TEAM_ID_W-1:0] reduce_team(input logic [TEAM_ID_W-1:0] x);
    logic [TEAM_ID_W-1:0] r;
    r = x;
    for (int i = TEAM_ID_W - 1; i >= 0; i--) begin
      if (r >= (NT << i)) begin
        r = r - TEAM_ID_W'(NT << i);
      end
    end
    return r;
  endfunction

  function automatic logic [SAW-1:0] slot(input logic [TW-1:0] t, input logic [HW-1:0] pos);
    return SAW'(t) * SAW'(TEAM_DEPTH) + SAW'(pos);
  endfunction

  logic              accept;
  logic [ELEM_W-1:0] in_elem;
  logic [TW-1:0]     mem_team;

  // stage one
  logic              s_valid;
  logic [ACT_W-1:0]  s_act;
  logic [ELEM_W-1:0] s_elem;

  // team and order state
  logic [HW-1:0]  team_head  [NT];
  logic [CW-1:0]  team_count [NT];
  logic [TW-1:0]  order_ring [NT];
  logic [TW-1:0]  order_head;
  logic [TW-1:0]  order_tail;
  logic [OCW-1:0] order_count;

  logic [ELEM_W-1:0] store [SD];
  logic [ELEM_W-1:0] store_q;
  logic              deq_sel;
  logic [STATUS_W-1:0] status_q;

  // stage two decode
  logic [TW-1:0]       t_enq;
  logic [TW-1:0]       t_deq;
  logic [TW-1:0]       t_sel;
  logic [CW-1:0]       cur_cnt;
  logic [HW-1:0]       cur_head;
  logic [HW:0]         psum;
  logic [HW-1:0]       wpos;
  logic [HW-1:0]       head_inc;
  logic [CW-1:0]       cnt_next;
  logic [HW-1:0]       head_next;
  logic [STATUS_W-1:0] status_next;
  logic                upd;
  logic                push;
  logic                pop;
  logic                st_we;
  logic                st_re;
  logic                deq_ok;
  logic [SAW-1:0]      st_waddr;
  logic [SAW-1:0]      st_raddr;

  assign accept  = start && !busy;
  assign in_elem = reduce_elem(cmd.element);

  gftq_membership #(
    .DEPTH (MD),
    .TW    (TW)
  ) u_membership (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && (cmd.action == ACT_ASSIGN)),
    .rd_en    (accept && (cmd.action == ACT_ENQUEUE)),
    .addr     (in_elem[MAW-1:0]),
    .wr_team  (TW'(reduce_team(cmd.team_id))),
    .rd_team  (mem_team),
    .clearing (busy)
  );

  always_comb begin
    t_enq    = mem_team;
    t_deq    = order_ring[order_head];
    t_sel    = (s_act == ACT_DEQUEUE) ? t_deq : t_enq;
    cur_cnt  = team_count[t_sel];
    cur_head = team_head[t_sel];
    psum     = (HW+1)'(cur_head) + (HW+1)'(cur_cnt);
    if (psum >= (HW+1)'(TEAM_DEPTH)) begin
      psum = psum - (HW+1)'(TEAM_DEPTH);
    end
    wpos     = psum[HW-1:0];
    head_inc = (cur_head == HW'(TEAM_DEPTH - 1)) ? '0 : cur_head + HW'(1);

    status_next = ST_OK;
    cnt_next    = cur_cnt;
    head_next   = cur_head;
    upd         = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    st_we       = 1'b0;
    st_re       = 1'b0;
    deq_ok      = 1'b0;
    if (s_valid) begin
      unique case (s_act)
        ACT_ENQUEUE: begin
          if (cur_cnt == CW'(TEAM_DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            upd      = 1'b1;
            st_we    = 1'b1;
            cnt_next = cur_cnt + CW'(1);
            push     = (cur_cnt == '0);
          end
        end
        ACT_DEQUEUE: begin
          if (order_count == '0 || cur_cnt == '0) begin
            status_next = ST_EMPTY;
          end else begin
            upd       = 1'b1;
            st_re     = 1'b1;
            deq_ok    = 1'b1;
            cnt_next  = cur_cnt - CW'(1);
            head_next = head_inc;
            pop       = (cur_cnt == CW'(1));
          end
        end
        default: ;
      endcase
    end
    st_waddr = slot(t_enq, wpos);
    st_raddr = slot(t_deq, cur_head);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid     <= 1'b0;
      done        <= 1'b0;
      order_head  <= '0;
      order_tail  <= '0;
      order_count <= '0;
      for (int i = 0; i < NT; i++) begin
        team_head[i]  <= '0;
        team_count[i] <= '0;
      end
    end else begin
      s_valid <= accept;
      done    <= s_valid;
      if (upd) begin
        team_count[t_sel] <= cnt_next;
        team_head[t_sel]  <= head_next;
      end
      if (push) begin
        order_tail  <= (order_tail == TW'(NT - 1)) ? '0 : order_tail + TW'(1);
        order_count <= order_count + OCW'(1);
      end else if (pop) begin
        order_head  <= (order_head == TW'(NT - 1)) ? '0 : order_head + TW'(1);
        order_count <= order_count - OCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_act  <= cmd.action;
      s_elem <= in_elem;
    end
    if (push) begin
      order_ring[order_tail] <= t_enq;
    end
    if (st_we) begin
      store[st_waddr] <= s_elem;
    end
    if (st_re) begin
      store_q <= store[st_raddr];
    end
    deq_sel  <= deq_ok;
    status_q <= status_next;
  end

  assign result.element_out = deq_sel ? store_q : '0;
  assign result.status      = status_q;

  a_done_follows_stage: assert property (@(posedge clk) disable iff (rst)
    s_valid |=> done)
    else $error("transaction in stage two produced no result");

  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    !s_valid |=> !done)
    else $error("result strobe without a transaction");

  a_quiet_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_valid)
    else $error("transaction in flight during membership clear");

  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    order_count <= OCW'(NT))
    else $error("order ring holds more teams than exist");

  a_empty_dequeue: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_act == ACT_DEQUEUE && order_count == '0) |=>
      (result.status == ST_EMPTY && result.element_out == '0))
    else $error("dequeue of empty queue not flagged");

endmodule
